/* rtl/quaternion_small_angle_update_core_defines.svh */
`ifndef QUATERNION_SMALL_ANGLE_UPDATE_CORE_DEFINES_SVH
`define QUATERNION_SMALL_ANGLE_UPDATE_CORE_DEFINES_SVH

// same-cycle property, sampled on clk, off during reset
`define QSAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// next-cycle property, sampled on clk, off during reset
`define QSAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/qsau_pkg.sv */
`timescale 1ns / 1ps
package qsau_pkg;

  localparam int GUARD_BITS  = 8;
  localparam int MAG_W       = 30;
  localparam int SQRT_STEPS  = 32;
  localparam int N2_W        = 64;
  localparam int ROOT_W      = 31;
  localparam int REM_W       = 62;
  localparam int LANES       = 4;

  typedef struct packed {
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic signed [31:0] quat_w;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } quat_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               zero_norm;
  } quat_out_t;

  // carried alongside the square root
  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    logic [LANES-1:0]            neg;
    logic                        zero;
  } qsau_sb_t;

  // carried alongside the divider
  typedef struct packed {
    logic [LANES-1:0] neg;
    logic             zero;
  } qsau_dsb_t;

endpackage

/* rtl/quaternion_small_angle_update_core.sv */
`timescale 1ns / 1ps
// path: front stages, square-root cells, dividend register, divider cells, output register
// throughput: one transaction per cycle when not stalled, set by the fully pipelined chain of
// 32 square-root cells and QUAT_FRAC_BITS + 1 divider cells
// the whole pipeline holds while a result waits under out_stall
// synchronous active-low reset clears the valid bits only
module quaternion_small_angle_update_core #(
  parameter int QUAT_FRAC_BITS  = 30,
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  qsau_pkg::quat_in_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output qsau_pkg::quat_out_t   out_data
);

  localparam int NS = qsau_pkg::SQRT_STEPS;
  localparam int QB = QUAT_FRAC_BITS + 1;
  localparam int L  = qsau_pkg::LANES;
  localparam int RW = qsau_pkg::REM_W;

  logic en;
  logic out_valid_r;
  qsau_pkg::quat_out_t out_data_r, out_data_nxt;

  logic                      s_vld [NS+1];
  logic [qsau_pkg::N2_W-1:0] s_n   [NS+1];
  logic [qsau_pkg::N2_W-1:0] s_res [NS+1];
  qsau_pkg::qsau_sb_t        s_sb  [NS+1];

  logic                            d_vld [QB+1];
  logic [L-1:0][RW-1:0]            d_rem [QB+1];
  logic [L-1:0][QB-1:0]            d_q   [QB+1];
  logic [qsau_pkg::ROOT_W-1:0]     d_s   [QB+1];
  qsau_pkg::qsau_dsb_t             d_sb  [QB+1];

  logic                            prep_vld_r;
  logic [L-1:0][RW-1:0]            prep_rem_r, prep_rem_nxt;
  logic [qsau_pkg::ROOT_W-1:0]     prep_s_r, root;
  qsau_pkg::qsau_dsb_t             prep_sb_r;

  logic signed [31:0] lane_val [L];

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  qsau_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .in_data (in_data),
    .out_vld (s_vld[0]),
    .out_n2  (s_n[0]),
    .out_sb  (s_sb[0])
  );

  assign s_res[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    qsau_sqrt_cell #(
      .STEP(k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (s_vld[k]),
      .in_n    (s_n[k]),
      .in_res  (s_res[k]),
      .in_sb   (s_sb[k]),
      .out_vld (s_vld[k+1]),
      .out_n   (s_n[k+1]),
      .out_res (s_res[k+1]),
      .out_sb  (s_sb[k+1])
    );
  end

  // dividend is the magnitude at the output scale plus half the root for rounding
  assign root = s_res[NS][qsau_pkg::ROOT_W-1:0];
  always_comb begin
    for (int l = 0; l < L; l++) begin
      prep_rem_nxt[l] = (RW'(s_sb[NS].mag[l]) << QUAT_FRAC_BITS) + RW'(root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (en) begin
      prep_vld_r <= s_vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_rem_r     <= prep_rem_nxt;
      prep_s_r       <= root;
      prep_sb_r.neg  <= s_sb[NS].neg;
      prep_sb_r.zero <= s_sb[NS].zero;
    end
  end

  assign d_vld[0] = prep_vld_r;
  assign d_rem[0] = prep_rem_r;
  assign d_q[0]   = '0;
  assign d_s[0]   = prep_s_r;
  assign d_sb[0]  = prep_sb_r;

  for (genvar j = 0; j < QB; j++) begin : g_div
    qsau_div_cell #(
      .QB (QB),
      .BIT(QB - 1 - j)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (d_vld[j]),
      .in_rem  (d_rem[j]),
      .in_q    (d_q[j]),
      .in_s    (d_s[j]),
      .in_sb   (d_sb[j]),
      .out_vld (d_vld[j+1]),
      .out_rem (d_rem[j+1]),
      .out_q   (d_q[j+1]),
      .out_s   (d_s[j+1]),
      .out_sb  (d_sb[j+1])
    );
  end

  // quotient stays below 2^31, so applying the sign cannot overflow
  always_comb begin
    for (int l = 0; l < L; l++) begin
      if (d_sb[QB].zero) begin
        lane_val[l] = '0;
      end else if (d_sb[QB].neg[l]) begin
        lane_val[l] = -$signed(32'(d_q[QB][l]));
      end else begin
        lane_val[l] = $signed(32'(d_q[QB][l]));
      end
    end
    out_data_nxt.out_x     = lane_val[0];
    out_data_nxt.out_y     = lane_val[1];
    out_data_nxt.out_z     = lane_val[2];
    out_data_nxt.out_w     = lane_val[3];
    out_data_nxt.zero_norm = d_sb[QB].zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_vld[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/qsau_front.sv */
`timescale 1ns / 1ps
module qsau_front #(
  parameter int ANGLE_FRAC_BITS = 28
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic                            in_vld,
  input  qsau_pkg::quat_in_t              in_data,
  output logic                            out_vld,
  output logic [qsau_pkg::N2_W-1:0]       out_n2,
  output qsau_pkg::qsau_sb_t              out_sb
);

  localparam int SH  = ANGLE_FRAC_BITS + 1 - qsau_pkg::GUARD_BITS;
  localparam int PW  = 66 - SH;
  localparam int LZW = $clog2(PW);
  localparam int MW  = qsau_pkg::MAG_W;

  localparam int WA = 0, YC = 1, ZB = 2, WB = 3, XC = 4, ZA = 5;
  localparam int WC = 6, XB = 7, YA = 8, XA = 9, YB = 10, ZC = 11;

  logic [6:0] vld_r;

  logic signed [63:0] prod_r [12];
  logic signed [63:0] prod_nxt [12];
  logic signed [31:0] qv_r [4];

  logic signed [PW-1:0] t [12];
  logic signed [PW-1:0] ix [4];
  logic signed [PW-1:0] p_r [4];
  logic signed [PW-1:0] p_nxt [4];

  logic [PW-1:0] mag3_r [4];
  logic [PW-1:0] mag3_nxt [4];
  logic [3:0]    neg3_r;
  logic [PW-1:0] or3_r;

  logic [PW-1:0] mag4_r [4];
  logic [3:0]    neg4_r;
  logic          zero4_r;
  logic [LZW-1:0] lz_r;
  logic [LZW-1:0] lz_nxt;

  logic [MW-1:0] sc5_r [4];
  logic [MW-1:0] sc5_nxt [4];
  logic [PW-1:0] shf [4];
  logic [3:0]    neg5_r;
  logic          zero5_r;

  logic [2*MW-1:0] sq6_r [4];
  qsau_pkg::qsau_sb_t sb6_r;
  qsau_pkg::qsau_sb_t sb7_r;
  logic [qsau_pkg::N2_W-1:0] n2_r;

  always_comb begin
    prod_nxt[WA] = in_data.quat_w * in_data.rot_x;
    prod_nxt[YC] = in_data.quat_y * in_data.rot_z;
    prod_nxt[ZB] = in_data.quat_z * in_data.rot_y;
    prod_nxt[WB] = in_data.quat_w * in_data.rot_y;
    prod_nxt[XC] = in_data.quat_x * in_data.rot_z;
    prod_nxt[ZA] = in_data.quat_z * in_data.rot_x;
    prod_nxt[WC] = in_data.quat_w * in_data.rot_z;
    prod_nxt[XB] = in_data.quat_x * in_data.rot_y;
    prod_nxt[YA] = in_data.quat_y * in_data.rot_x;
    prod_nxt[XA] = in_data.quat_x * in_data.rot_x;
    prod_nxt[YB] = in_data.quat_y * in_data.rot_y;
    prod_nxt[ZC] = in_data.quat_z * in_data.rot_z;
  end

  // cross terms floor-shifted down to the guard-extended quaternion scale
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      t[k] = PW'(prod_r[k] >>> SH);
    end
    for (int k = 0; k < 4; k++) begin
      ix[k] = PW'(qv_r[k]) <<< qsau_pkg::GUARD_BITS;
    end
    p_nxt[0] = ix[0] + t[WA] + t[YC] - t[ZB];
    p_nxt[1] = ix[1] + t[WB] - t[XC] + t[ZA];
    p_nxt[2] = ix[2] + t[WC] + t[XB] - t[YA];
    p_nxt[3] = ix[3] - t[XA] - t[YB] - t[ZC];
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mag3_nxt[k] = p_r[k][PW-1] ? PW'(-p_r[k]) : PW'(p_r[k]);
    end
  end

  // bit length of the largest magnitude equals that of the or of all four
  always_comb begin
    lz_nxt = '0;
    for (int i = 0; i < PW; i++) begin
      if (or3_r[i]) begin
        lz_nxt = LZW'(PW - 1 - i);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      shf[k]     = mag4_r[k] << lz_r;
      sc5_nxt[k] = shf[k][PW-1 -: MW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 12; k++) begin
        prod_r[k] <= prod_nxt[k];
      end
      qv_r[0] <= in_data.quat_x;
      qv_r[1] <= in_data.quat_y;
      qv_r[2] <= in_data.quat_z;
      qv_r[3] <= in_data.quat_w;

      for (int k = 0; k < 4; k++) begin
        p_r[k]    <= p_nxt[k];
        mag3_r[k] <= mag3_nxt[k];
        neg3_r[k] <= p_r[k][PW-1];
        mag4_r[k] <= mag3_r[k];
        sc5_r[k]  <= sc5_nxt[k];
        sq6_r[k]  <= sc5_r[k] * sc5_r[k];
        sb6_r.mag[k] <= sc5_r[k];
      end
      or3_r   <= mag3_nxt[0] | mag3_nxt[1] | mag3_nxt[2] | mag3_nxt[3];
      neg4_r  <= neg3_r;
      zero4_r <= ~|or3_r;
      lz_r    <= lz_nxt;
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
      sb6_r.neg  <= neg5_r;
      sb6_r.zero <= zero5_r;
      sb7_r <= sb6_r;
      n2_r  <= qsau_pkg::N2_W'(sq6_r[0]) + qsau_pkg::N2_W'(sq6_r[1])
             + qsau_pkg::N2_W'(sq6_r[2]) + qsau_pkg::N2_W'(sq6_r[3]);
    end
  end

  assign out_vld = vld_r[6];
  assign out_n2  = n2_r;
  assign out_sb  = sb7_r;

endmodule

/* rtl/qsau_sqrt_cell.sv */
`timescale 1ns / 1ps
module qsau_sqrt_cell #(
  parameter int STEP = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [qsau_pkg::N2_W-1:0] in_n,
  input  logic [qsau_pkg::N2_W-1:0] in_res,
  input  qsau_pkg::qsau_sb_t        in_sb,
  output logic                      out_vld,
  output logic [qsau_pkg::N2_W-1:0] out_n,
  output logic [qsau_pkg::N2_W-1:0] out_res,
  output qsau_pkg::qsau_sb_t        out_sb
);

  localparam logic [qsau_pkg::N2_W-1:0] BITV =
    qsau_pkg::N2_W'(1) << (2 * (qsau_pkg::SQRT_STEPS - 1 - STEP));

  logic                      vld_r;
  logic [qsau_pkg::N2_W-1:0] n_r, n_nxt, res_r, res_nxt, trial;
  qsau_pkg::qsau_sb_t        sb_r;

  always_comb begin
    trial = in_res + BITV;
    if (in_n >= trial) begin
      n_nxt   = in_n - trial;
      res_nxt = (in_res >> 1) + BITV;
    end else begin
      n_nxt   = in_n;
      res_nxt = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r   <= n_nxt;
      res_r <= res_nxt;
      sb_r  <= in_sb;
    end
  end

  assign out_vld = vld_r;
  assign out_n   = n_r;
  assign out_res = res_r;
  assign out_sb  = sb_r;

endmodule

/* rtl/qsau_div_cell.sv */
`timescale 1ns / 1ps
module qsau_div_cell #(
  parameter int QB  = 31,
  parameter int BIT = 0
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              en,
  input  logic                                              in_vld,
  input  logic [qsau_pkg::LANES-1:0][qsau_pkg::REM_W-1:0]   in_rem,
  input  logic [qsau_pkg::LANES-1:0][QB-1:0]                in_q,
  input  logic [qsau_pkg::ROOT_W-1:0]                       in_s,
  input  qsau_pkg::qsau_dsb_t                               in_sb,
  output logic                                              out_vld,
  output logic [qsau_pkg::LANES-1:0][qsau_pkg::REM_W-1:0]   out_rem,
  output logic [qsau_pkg::LANES-1:0][QB-1:0]                out_q,
  output logic [qsau_pkg::ROOT_W-1:0]                       out_s,
  output qsau_pkg::qsau_dsb_t                               out_sb
);

  logic                                            vld_r;
  logic [qsau_pkg::LANES-1:0][qsau_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [qsau_pkg::LANES-1:0][QB-1:0]              q_r, q_nxt;
  logic [qsau_pkg::ROOT_W-1:0]                     s_r;
  qsau_pkg::qsau_dsb_t                             sb_r;
  logic [qsau_pkg::REM_W-1:0]                      dvs;

  // restoring step: one quotient bit per lane
  always_comb begin
    dvs     = qsau_pkg::REM_W'(in_s) << BIT;
    rem_nxt = in_rem;
    q_nxt   = in_q;
    for (int l = 0; l < qsau_pkg::LANES; l++) begin
      if (in_rem[l] >= dvs) begin
        rem_nxt[l]    = in_rem[l] - dvs;
        q_nxt[l][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      s_r   <= in_s;
      sb_r  <= in_sb;
    end
  end

  assign out_vld = vld_r;
  assign out_rem = rem_r;
  assign out_q   = q_r;
  assign out_s   = s_r;
  assign out_sb  = sb_r;

endmodule

/* rtl/qsau_checker.sv */
`timescale 1ns / 1ps
`include "quaternion_small_angle_update_core_defines.svh"
module qsau_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input qsau_pkg::quat_out_t out_data
);

  logic comp_zero;
  assign comp_zero = ({out_data.out_x, out_data.out_y, out_data.out_z, out_data.out_w} == '0);

  `QSAU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result transaction changed")
  `QSAU_ASSERT(a_stall_cause, in_stall |-> (out_valid && out_stall), "input stalled without a blocked result")
  `QSAU_ASSERT(a_zero_out, (out_valid && out_data.zero_norm) |-> comp_zero, "zero norm with nonzero components")
  `QSAU_ASSERT(a_nonzero_out, (out_valid && !out_data.zero_norm) |-> !comp_zero, "normalized result is all zero")

endmodule

bind quaternion_small_angle_update_core qsau_checker u_qsau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
